### rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// types and constants shared by the indexed list store modules
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned PosW   = 5;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    REQ_GET    = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_INSERT = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_UP,
    S_PUT,
    S_RM,
    S_DN,
    S_DONE
  } state_e;

  typedef struct packed {
    req_e             req_type;
    logic [PosW-1:0]  position;
    logic [ValW-1:0]  item_value;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [ValW-1:0]   read_value;
    logic [CountW-1:0] count;
  } out_item_t;

  // top level to sequencer
  typedef struct packed {
    logic start;
    logic out_free;
  } seq_ctl_t;

  // sequencer to top level
  typedef struct packed {
    logic busy;
    logic done;
  } seq_sts_t;

endpackage

### rtl/ils_mem.sv
// ----------------------------------------------------------------------------
// ils_mem
// element storage: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module ils_mem #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [ELEMENT_WIDTH-1:0]                   wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [ELEMENT_WIDTH-1:0]                   rdata_o
);

  logic [ELEMENT_WIDTH-1:0] mem_q [DEPTH];
  logic [ELEMENT_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ils_seq.sv
// ----------------------------------------------------------------------------
// ils_seq
// request sequencer: range checks, fill count and the one-entry-per-cycle
// shift through the storage using a shared index counter
// ----------------------------------------------------------------------------
module ils_seq #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  ils_pkg::seq_ctl_t                          ctl_i,
  input  ils_pkg::in_item_t                          req_i,
  output ils_pkg::seq_sts_t                          sts_o,
  output ils_pkg::out_item_t                         res_o,
  output logic                                       mem_we_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_waddr_o,
  output logic [ELEMENT_WIDTH-1:0]                   mem_wdata_o,
  output logic                                       mem_re_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_raddr_o,
  input  logic [ELEMENT_WIDTH-1:0]                   mem_rdata_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > ils_pkg::PosW) ? CW : ils_pkg::PosW;
  localparam int unsigned EW = ELEMENT_WIDTH;

  ils_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [EW-1:0]    val_q, val_d;
  logic [EW-1:0]    rval_q, rval_d;
  ils_pkg::status_e status_q, status_d;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] fill_w;
  logic          pos_ge_fill;
  logic          pos_gt_fill;
  logic          at_end;
  logic          full;
  logic          next_in_range;
  logic          idx_is_pos;

  assign pos_w         = PW'(req_i.position);
  assign fill_w        = PW'(fill_q);
  assign pos_ge_fill   = pos_w >= fill_w;
  assign pos_gt_fill   = pos_w > fill_w;
  assign at_end        = pos_w == fill_w;
  assign full          = fill_q == CW'(DEPTH);
  assign next_in_range = (CW'(idx_q) + CW'(1)) < fill_q;
  assign idx_is_pos    = idx_q == pos_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ils_pkg::S_IDLE: begin
        if (ctl_i.start) begin
          unique case (req_i.req_type)
            ils_pkg::REQ_GET: begin
              state_d = pos_ge_fill ? ils_pkg::S_DONE : ils_pkg::S_GET;
            end
            ils_pkg::REQ_APPEND: begin
              state_d = ils_pkg::S_DONE;
            end
            ils_pkg::REQ_INSERT: begin
              if (pos_gt_fill || full || at_end) begin
                state_d = ils_pkg::S_DONE;
              end else begin
                state_d = ils_pkg::S_UP;
              end
            end
            ils_pkg::REQ_REMOVE: begin
              state_d = pos_ge_fill ? ils_pkg::S_DONE : ils_pkg::S_RM;
            end
            default: state_d = ils_pkg::S_DONE;
          endcase
        end
      end
      ils_pkg::S_GET: state_d = ils_pkg::S_DONE;
      ils_pkg::S_UP:  state_d = idx_is_pos ? ils_pkg::S_PUT : ils_pkg::S_UP;
      ils_pkg::S_PUT: state_d = ils_pkg::S_DONE;
      ils_pkg::S_RM, ils_pkg::S_DN: begin
        state_d = next_in_range ? ils_pkg::S_DN : ils_pkg::S_DONE;
      end
      ils_pkg::S_DONE: begin
        if (ctl_i.out_free) begin
          state_d = ils_pkg::S_IDLE;
        end
      end
      default: state_d = ils_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fill_d      = fill_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    val_d       = val_q;
    rval_d      = rval_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    sts_o.busy  = state_q != ils_pkg::S_IDLE;
    sts_o.done  = 1'b0;
    unique case (state_q)
      ils_pkg::S_IDLE: begin
        if (ctl_i.start) begin
          rval_d   = '0;
          status_d = ils_pkg::ST_OK;
          unique case (req_i.req_type)
            ils_pkg::REQ_GET: begin
              if (pos_ge_fill) begin
                status_d = ils_pkg::ST_RANGE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AW'(req_i.position);
              end
            end
            ils_pkg::REQ_APPEND: begin
              if (full) begin
                status_d = ils_pkg::ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AW'(fill_q);
                mem_wdata_o = EW'(req_i.item_value);
                fill_d      = fill_q + CW'(1);
              end
            end
            ils_pkg::REQ_INSERT: begin
              if (pos_gt_fill) begin
                status_d = ils_pkg::ST_RANGE;
              end else if (full) begin
                status_d = ils_pkg::ST_FULL;
              end else if (at_end) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AW'(req_i.position);
                mem_wdata_o = EW'(req_i.item_value);
                fill_d      = fill_q + CW'(1);
              end else begin
                // start from the last entry and walk down to the slot
                mem_re_o    = 1'b1;
                mem_raddr_o = AW'(fill_q - CW'(1));
                idx_d       = AW'(fill_q - CW'(1));
                pos_d       = AW'(req_i.position);
                val_d       = EW'(req_i.item_value);
              end
            end
            ils_pkg::REQ_REMOVE: begin
              if (pos_ge_fill) begin
                status_d = ils_pkg::ST_RANGE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AW'(req_i.position);
                idx_d       = AW'(req_i.position);
              end
            end
            default: status_d = ils_pkg::ST_RANGE;
          endcase
        end
      end
      ils_pkg::S_GET: begin
        rval_d = mem_rdata_i;
      end
      ils_pkg::S_UP: begin
        // move entry idx up by one, fetch the one below
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q + AW'(1);
        mem_wdata_o = mem_rdata_i;
        if (!idx_is_pos) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q - AW'(1);
          idx_d       = idx_q - AW'(1);
        end
      end
      ils_pkg::S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = val_q;
        fill_d      = fill_q + CW'(1);
      end
      ils_pkg::S_RM, ils_pkg::S_DN: begin
        if (state_q == ils_pkg::S_RM) begin
          rval_d = mem_rdata_i;
        end else begin
          // move entry idx down by one
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_q - AW'(1);
          mem_wdata_o = mem_rdata_i;
        end
        if (next_in_range) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + AW'(1);
          idx_d       = idx_q + AW'(1);
        end else begin
          fill_d = fill_q - CW'(1);
        end
      end
      ils_pkg::S_DONE: begin
        sts_o.done = ctl_i.out_free;
      end
      default: ;
    endcase
  end

  assign res_o.status     = status_q;
  assign res_o.read_value = ils_pkg::ValW'(rval_q);
  assign res_o.count      = ils_pkg::CountW'(fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ils_pkg::S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    rval_q   <= rval_d;
    status_q <= status_d;
  end

endmodule

### rtl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// fixed-capacity ordered list with get, append, insert and remove requests
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid_i / in_stall_o carry one request item (in_i); an
//   item is taken at an edge with valid high and stall low. in_stall_o is
//   high from the accepting edge on until the result is handed to the
//   output register, so one request is worked on at a time.
//   out channel: out_valid_o / out_stall_i carry one result item (out_o)
//   per request: status, element read or removed, and the length after it.
//   steps after accept: append, failed requests and an insert at the end
//   go straight to S_DONE; get reads in S_GET first; insert moves entries
//   up one from the end down to the index in S_UP, then writes the item in
//   S_PUT; remove reads in S_RM, then moves later entries down in S_DN.
//   a new request is taken in the cycle after the result is registered.
//   the shift loop moves one entry per cycle through both storage ports.
//   stall: the result sits in the output register while out_stall_i is
//   high; a finished request whose register is still full waits in the
//   sequencer and holds in_stall_o high.
//   reset: the list is empty (length 0); element storage is not cleared,
//   only entries below the length are ever read.
// ----------------------------------------------------------------------------
module indexed_list_store #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ils_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ils_pkg::out_item_t out_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ils_pkg::seq_ctl_t  ctl;
  ils_pkg::seq_sts_t  sts;
  ils_pkg::out_item_t res;

  // storage port wires
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;

  // output register
  logic               out_valid_q, out_valid_d;
  ils_pkg::out_item_t out_q;

  // only idle sequencer takes a new item
  assign in_stall_o   = sts.busy;
  assign ctl.start    = in_valid_i && !sts.busy;
  // output register empty, or emptied at this edge
  assign ctl.out_free = !out_valid_q || !out_stall_i;

  ils_seq #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .req_i       (in_i),
    .sts_o       (sts),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ils_mem #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // result item loads only when the register is free, so nothing is lost
  always_comb begin
    out_valid_d = out_valid_q;
    if (sts.done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sts.done) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
